>>> hw/rtl/box_filter_frame_downscaler_assert.svh
// assertion macros used by the checker
`ifndef BOX_FILTER_FRAME_DOWNSCALER_ASSERT_SVH
`define BOX_FILTER_FRAME_DOWNSCALER_ASSERT_SVH

// checked outside reset
`define BFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bfd_pkg.sv
package bfd_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int IN_SIZE_W     = 12;
   localparam int OUT_SIZE_W    = 11;
   localparam int STEP_W        = 28;
   localparam int SUM_W         = 16;
   localparam int CNT_W         = 9;
   localparam int EXT_W         = 5;
   localparam int MEM_AW        = 10;
   localparam int MAX_IN_WIDTH  = 2048;
   localparam int MAX_OUT_WIDTH = 1024;
   localparam int MAX_FACTOR    = 16;
   localparam int PADDR_W       = 5;
   localparam int LANES         = 3;

   typedef enum logic [2:0] {
      REG_IN_WIDTH   = 3'd0,
      REG_IN_HEIGHT  = 3'd1,
      REG_OUT_WIDTH  = 3'd2,
      REG_OUT_HEIGHT = 3'd3,
      REG_YUV_MODE   = 3'd4
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef struct packed {
      logic                            start;
      logic [CNT_W-1:0]                count;
      logic [LANES-1:0][SUM_W-1:0]     sums;
   } avg_req_type;

endpackage

>>> hw/rtl/bfd_req_if.sv
interface bfd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_data;
   logic        start_of_frame;

   modport source (output valid, pixel_data, start_of_frame, input ready);
   modport sink (input valid, pixel_data, start_of_frame, output ready);
endinterface

>>> hw/rtl/bfd_rsp_if.sv
interface bfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_data;
   logic        last_of_frame;

   modport source (output valid, out_data, last_of_frame, input ready);
   modport sink (input valid, out_data, last_of_frame, output ready);
endinterface

>>> hw/rtl/box_filter_frame_downscaler.sv
// a pixel that closes a box passes the averaging divider and the output register
//   before its result shows; a new pixel waits until the last is through the
//   line-store read-modify-write and the bit-serial 16-step averaging divider
// after reset and after every register write the steps are recomputed by the
//   bit-serial 28-step divider, with req.ready low meanwhile
// reset is synchronous, active high; the line store needs no clearing pass
module box_filter_frame_downscaler
   import bfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   bfd_req_if.sink            req,
   bfd_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // configuration registers
   logic [IN_SIZE_W-1:0]  iw_ff, ih_ff;
   logic [OUT_SIZE_W-1:0] ow_ff, oh_ff;
   logic                  yuv_ff;
   logic                  cfg_wr, cfg_wr_ff;
   reg_idx_type           reg_idx;

   // frame position state
   state_type             state_ff, state_in;
   logic [10:0]           col_ff, col_in;
   logic [IN_SIZE_W-1:0]  row_ff, row_in;
   logic [STEP_W-1:0]     bxo_ff, bxo_in, byo_ff, byo_in;
   logic [10:0]           oc_ff, oc_in, orow_ff, orow_in;
   logic [31:0]           pend_ff, pend_in;

   // item being worked on
   logic [31:0]           pix_ff;
   logic                  sof_ff;
   logic [3*SUM_W-1:0]    mem_rd_ff;
   logic                  res_yuv_ff, res_yuv_in, res_odd_ff, res_odd_in;
   logic                  res_lastcol_ff, res_lastcol_in, res_last_ff, res_last_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // per-column sums line store
   logic [3*SUM_W-1:0]    line_mem [MAX_OUT_WIDTH];
   logic                  mem_we;
   logic [MEM_AW-1:0]     mem_waddr, mem_raddr;
   logic [3*SUM_W-1:0]    mem_wdata;

   logic                  step_busy;
   logic [STEP_W-1:0]     step_x, step_y;
   avg_req_type           avg_req;
   logic                  avg_done;
   logic [LANES-1:0][SUM_W-1:0] avg_quo;

   logic                  accept;

   // working values of the current pixel
   logic [10:0]           cc, oc, orow;
   logic [IN_SIZE_W-1:0]  rr;
   logic [STEP_W-1:0]     bxo, byo;
   logic [IN_SIZE_W-1:0]  ox, oy, ex_raw, ey_raw;
   logic [EXT_W-1:0]      ex, ey;
   logic [12:0]           ox_end, oy_end;
   logic                  cfg_ok, in_row, hit, first, col_end, box_done;
   logic [SUM_W-1:0]      va, vb, vd;
   logic [LANES-1:0][SUM_W-1:0] old_sums, new_sums;
   logic                  out_needed, can_load;
   logic [31:0]           even_word;

   // ---------------------------------------------------------------- config port
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[PADDR_W-1:2]);

   always_comb begin
      unique case (reg_idx)
         REG_IN_WIDTH:   prdata = 32'(iw_ff);
         REG_IN_HEIGHT:  prdata = 32'(ih_ff);
         REG_OUT_WIDTH:  prdata = 32'(ow_ff);
         REG_OUT_HEIGHT: prdata = 32'(oh_ff);
         REG_YUV_MODE:   prdata = 32'(yuv_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff     <= IN_SIZE_W'(640);
         ih_ff     <= IN_SIZE_W'(480);
         ow_ff     <= OUT_SIZE_W'(320);
         oh_ff     <= OUT_SIZE_W'(240);
         yuv_ff    <= 1'b0;
         cfg_wr_ff <= 1'b1;   // kick the step computation out of reset
      end else begin
         cfg_wr_ff <= cfg_wr;
         if (cfg_wr) begin
            unique case (reg_idx)
               REG_IN_WIDTH:   iw_ff  <= pwdata[IN_SIZE_W-1:0];
               REG_IN_HEIGHT:  ih_ff  <= pwdata[IN_SIZE_W-1:0];
               REG_OUT_WIDTH:  ow_ff  <= pwdata[OUT_SIZE_W-1:0];
               REG_OUT_HEIGHT: oh_ff  <= pwdata[OUT_SIZE_W-1:0];
               REG_YUV_MODE:   yuv_ff <= pwdata[0];
               default: ;
            endcase
         end
      end
   end

   // fixed-point steps, recomputed after each register write
   bfd_step u_step (
      .clock      (clock),
      .reset      (reset),
      .start      (cfg_wr_ff),
      .in_width   (iw_ff),
      .in_height  (ih_ff),
      .out_width  (ow_ff),
      .out_height (oh_ff),
      .busy       (step_busy),
      .step_x     (step_x),
      .step_y     (step_y)
   );

   // ---------------------------------------------------------------- input side
   assign req.ready = (state_ff == ST_IDLE) && !step_busy && !cfg_wr_ff;
   assign accept    = req.valid && req.ready;

   // start of frame reads column 0
   assign mem_raddr = req.start_of_frame ? '0 : oc_ff[MEM_AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         mem_rd_ff <= line_mem[mem_raddr];
         pix_ff    <= req.pixel_data;
         sof_ff    <= req.start_of_frame;
      end
   end

   // ---------------------------------------------------------------- box logic
   always_comb begin
      // start of frame wipes the position state before the pixel counts
      cc   = sof_ff ? '0 : col_ff;
      rr   = sof_ff ? '0 : row_ff;
      bxo  = sof_ff ? '0 : bxo_ff;
      byo  = sof_ff ? '0 : byo_ff;
      oc   = sof_ff ? '0 : oc_ff;
      orow = sof_ff ? '0 : orow_ff;

      cfg_ok = (iw_ff != '0) && (ih_ff != '0) && (ow_ff != '0) && (oh_ff != '0) &&
               ({1'b0, ow_ff} <= iw_ff) && ({1'b0, oh_ff} <= ih_ff) &&
               (iw_ff <= IN_SIZE_W'(MAX_IN_WIDTH)) &&
               (ow_ff <= OUT_SIZE_W'(MAX_OUT_WIDTH));

      ox     = bxo[STEP_W-1:FRAC_BITS];
      oy     = byo[STEP_W-1:FRAC_BITS];
      ex_raw = step_x[STEP_W-1:FRAC_BITS];
      ey_raw = step_y[STEP_W-1:FRAC_BITS];
      // box extent capped at the largest factor
      ex = (ex_raw > IN_SIZE_W'(MAX_FACTOR)) ? EXT_W'(MAX_FACTOR) : ex_raw[EXT_W-1:0];
      ey = (ey_raw > IN_SIZE_W'(MAX_FACTOR)) ? EXT_W'(MAX_FACTOR) : ey_raw[EXT_W-1:0];
      ox_end = {1'b0, ox} + 13'(ex);
      oy_end = {1'b0, oy} + 13'(ey);

      in_row = (orow < oh_ff) && (rr >= oy) && (13'(rr) < oy_end);
      hit    = in_row && (oc < ow_ff) && (oc < 11'(MAX_OUT_WIDTH)) &&
               ({1'b0, cc} >= ox) && (13'(cc) < ox_end);
      first    = (rr == oy) && ({1'b0, cc} == ox);
      col_end  = hit && (13'(cc) == ox_end - 13'd1);
      box_done = col_end && (13'(rr) == oy_end - 13'd1);

      // channel pick: yuv luma by column parity
      if (yuv_ff) begin
         va = SUM_W'(cc[0] ? pix_ff[23:16] : pix_ff[7:0]);
         vb = SUM_W'(pix_ff[15:8]);
         vd = SUM_W'(pix_ff[31:24]);
      end else begin
         va = SUM_W'(pix_ff[14:10]);
         vb = SUM_W'(pix_ff[9:5]);
         vd = SUM_W'(pix_ff[4:0]);
      end

      old_sums = mem_rd_ff;
      new_sums[0] = first ? va : old_sums[0] + va;
      new_sums[1] = first ? vb : old_sums[1] + vb;
      new_sums[2] = first ? vd : old_sums[2] + vd;
   end

   assign mem_we    = (state_ff == ST_CALC) && cfg_ok && hit;
   assign mem_waddr = oc[MEM_AW-1:0];
   assign mem_wdata = new_sums;

   assign avg_req.start = (state_ff == ST_CALC) && cfg_ok && box_done;
   assign avg_req.count = CNT_W'(ex) * CNT_W'(ey);
   assign avg_req.sums  = new_sums;

   bfd_avg u_avg (
      .clock   (clock),
      .reset   (reset),
      .avg_req (avg_req),
      .done    (avg_done),
      .quo     (avg_quo)
   );

   // ---------------------------------------------------------------- result packing
   assign even_word  = {avg_quo[2][7:0], 8'd0, avg_quo[1][7:0], avg_quo[0][7:0]};
   assign out_needed = !res_yuv_ff || res_odd_ff || res_lastcol_ff;
   assign can_load   = !rsp_valid_ff || rsp.ready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      bxo_in         = bxo_ff;
      byo_in         = byo_ff;
      oc_in          = oc_ff;
      orow_in        = orow_ff;
      pend_in        = pend_ff;
      res_yuv_in     = res_yuv_ff;
      res_odd_in     = res_odd_ff;
      res_lastcol_in = res_lastcol_ff;
      res_last_in    = res_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_IDLE;
            // cleared state sticks even when the sizes are rejected
            col_in  = cc;
            row_in  = rr;
            bxo_in  = bxo;
            byo_in  = byo;
            oc_in   = oc;
            orow_in = orow;
            if (sof_ff) begin
               pend_in = '0;
            end
            if (cfg_ok) begin
               if (col_end) begin
                  oc_in  = oc + 11'd1;
                  bxo_in = bxo + step_x;
               end
               if (box_done) begin
                  state_in       = ST_DIV;
                  res_yuv_in     = yuv_ff;
                  res_odd_in     = oc[0];
                  res_lastcol_in = (oc == ow_ff - 11'd1);
                  res_last_in    = (oc == ow_ff - 11'd1) && (orow == oh_ff - 11'd1);
               end
               // end of input line
               if (12'(cc) + 12'd1 >= iw_ff) begin
                  col_in = '0;
                  bxo_in = '0;
                  oc_in  = '0;
                  if ((orow < oh_ff) && (13'(rr) + 13'd1 >= oy_end)) begin
                     orow_in = orow + 11'd1;
                     byo_in  = byo + step_y;
                  end
                  // frame wrap
                  if (rr + 12'd1 >= ih_ff) begin
                     row_in  = '0;
                     byo_in  = '0;
                     orow_in = '0;
                  end else begin
                     row_in = rr + 12'd1;
                  end
               end else begin
                  col_in = cc + 11'd1;
               end
            end
         end
         ST_DIV: begin
            if (avg_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_needed) begin
               // even yuv pixel waits for its odd partner
               pend_in  = even_word;
               state_in = ST_IDLE;
            end else if (can_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_last_in  = res_last_ff;
               if (!res_yuv_ff) begin
                  rsp_data_in = {16'd0, 1'b1, avg_quo[0][4:0], avg_quo[1][4:0],
                                 avg_quo[2][4:0]};
               end else if (res_odd_ff) begin
                  rsp_data_in = pend_ff | {8'd0, avg_quo[0][7:0], 16'd0};
               end else begin
                  // last even pixel of a row goes out alone
                  pend_in     = even_word;
                  rsp_data_in = even_word;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         bxo_ff       <= '0;
         byo_ff       <= '0;
         oc_ff        <= '0;
         orow_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         bxo_ff       <= bxo_in;
         byo_ff       <= byo_in;
         oc_ff        <= oc_in;
         orow_ff      <= orow_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_yuv_ff     <= res_yuv_in;
      res_odd_ff     <= res_odd_in;
      res_lastcol_ff <= res_lastcol_in;
      res_last_ff    <= res_last_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_data      = rsp_data_ff;
   assign rsp.last_of_frame = rsp_last_ff;

endmodule

>>> hw/rtl/bfd_step.sv
// two restoring dividers: (in << FRAC_BITS) / out for both axes
module bfd_step
   import bfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IN_SIZE_W-1:0]  in_width,
   input  logic [IN_SIZE_W-1:0]  in_height,
   input  logic [OUT_SIZE_W-1:0] out_width,
   input  logic [OUT_SIZE_W-1:0] out_height,
   output logic                  busy,
   output logic [STEP_W-1:0]     step_x,
   output logic [STEP_W-1:0]     step_y
);

   logic                                busy_ff, busy_in;
   logic [4:0]                          cnt_ff, cnt_in;
   logic [1:0][STEP_W-1:0]              num_ff, num_in;
   logic [1:0][OUT_SIZE_W-1:0]          rem_ff, rem_in;
   logic [1:0][OUT_SIZE_W-1:0]          div_ff, div_in;
   logic [1:0][OUT_SIZE_W:0]            trial;
   logic [1:0]                          ge;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      for (int i = 0; i < 2; i++) begin
         trial[i] = {rem_ff[i], num_ff[i][STEP_W-1]};
         ge[i]    = trial[i] >= {1'b0, div_ff[i]};
      end
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         num_in[0] = STEP_W'({in_width, {FRAC_BITS{1'b0}}});
         num_in[1] = STEP_W'({in_height, {FRAC_BITS{1'b0}}});
         rem_in    = '0;
         div_in[0] = out_width;
         div_in[1] = out_height;
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            rem_in[i] = ge[i] ? OUT_SIZE_W'(trial[i] - {1'b0, div_ff[i]})
                              : trial[i][OUT_SIZE_W-1:0];
            num_in[i] = {num_ff[i][STEP_W-2:0], ge[i]};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEP_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy   = busy_ff;
   assign step_x = num_ff[0];
   assign step_y = num_ff[1];

endmodule

>>> hw/rtl/bfd_avg.sv
// three-lane restoring divider: box sums over pixel count, one bit per cycle
module bfd_avg
   import bfd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  avg_req_type                  avg_req,
   output logic                         done,
   output logic [LANES-1:0][SUM_W-1:0]  quo
);

   logic                            busy_ff, busy_in;
   logic [3:0]                      cnt_ff, cnt_in;
   logic [CNT_W-1:0]                div_ff, div_in;
   logic [LANES-1:0][SUM_W-1:0]     num_ff, num_in;
   logic [LANES-1:0][CNT_W-1:0]     rem_ff, rem_in;
   logic [LANES-1:0][CNT_W:0]       trial;
   logic [LANES-1:0]                ge;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {rem_ff[i], num_ff[i][SUM_W-1]};
         ge[i]    = trial[i] >= {1'b0, div_ff};
      end
      if (avg_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = avg_req.count;
         num_in  = avg_req.sums;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            rem_in[i] = ge[i] ? CNT_W'(trial[i] - {1'b0, div_ff})
                              : trial[i][CNT_W-1:0];
            num_in[i] = {num_ff[i][SUM_W-2:0], ge[i]};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(SUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done = busy_ff && (cnt_ff == 4'(SUM_W - 1));
   assign quo  = num_ff;

endmodule

>>> hw/rtl/bfd_chk.sv
`include "box_filter_frame_downscaler_assert.svh"

module bfd_chk
   import bfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   bfd_req_if.sink            req,
   bfd_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite
);

   `BFD_ASSERT_ALWAYS(a_rst_no_rsp, clock, reset |=> !rsp.valid, "result valid after reset")
   `BFD_ASSERT_ALWAYS(a_rst_busy, clock, reset |=> !req.ready, "ready right after reset")
   `BFD_ASSERT(a_cfg_busy, clock, reset, (psel && penable && pwrite) |=> !req.ready, "ready during step update")
   `BFD_ASSERT(a_one_at_time, clock, reset, (req.valid && req.ready) |=> !req.ready, "back to back transfer")
   `BFD_ASSERT(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.out_data)), "stalled result changed")

endmodule

bind box_filter_frame_downscaler bfd_chk u_bfd_chk (
   .clock   (clock),
   .reset   (reset),
   .req     (req),
   .rsp     (rsp),
   .psel    (psel),
   .penable (penable),
   .pwrite  (pwrite)
);

>>> tb/sv/box_filter_frame_downscaler_tb.sv
import bfd_pkg::*;

typedef struct {
   logic [31:0] data;
   logic        last;
} out_word_type;

class downscale_scoreboard;
   // register copy
   int unsigned in_w, in_h, out_w, out_h;
   bit          yuv;
   // frame position
   int unsigned col, row, ocol, orow;
   longint unsigned x_org, y_org;
   int unsigned lane_sum[MAX_OUT_WIDTH][3];
   logic [31:0] even_word;
   out_word_type expected_words[$];
   int          mismatches;

   function new();
      in_w = 640; in_h = 480; out_w = 320; out_h = 240; yuv = 0;
      col = 0; row = 0; ocol = 0; orow = 0; x_org = 0; y_org = 0;
      even_word = '0;
      mismatches = 0;
      foreach (lane_sum[i, j]) lane_sum[i][j] = 0;
   endfunction

   function void set_reg(reg_idx_type idx, logic [31:0] v);
      case (idx)
         REG_IN_WIDTH:   in_w = v[11:0];
         REG_IN_HEIGHT:  in_h = v[11:0];
         REG_OUT_WIDTH:  out_w = v[10:0];
         REG_OUT_HEIGHT: out_h = v[10:0];
         REG_YUV_MODE:   yuv = v[0];
         default: ;
      endcase
   endfunction

   function bit sizes_ok();
      return !(in_w == 0 || in_h == 0 || out_w == 0 || out_h == 0 || out_w > in_w ||
               out_h > in_h || in_w > MAX_IN_WIDTH || out_w > MAX_OUT_WIDTH);
   endfunction

   // one accepted pixel: advance position, queue a word if a closed box completes one
   function void note_pixel(logic [31:0] pix, logic sof);
      longint unsigned sx, sy, ox, oy, ex, ey;
      int unsigned a, b, d, cnt;
      bit last_col, last;
      out_word_type w;
      if (sof) begin
         col = 0; row = 0; ocol = 0; orow = 0; x_org = 0; y_org = 0; even_word = '0;
      end
      if (!sizes_ok()) return;
      sx = (longint'(in_w) << FRAC_BITS) / out_w;
      sy = (longint'(in_h) << FRAC_BITS) / out_h;
      ex = (sx >> FRAC_BITS) > MAX_FACTOR ? MAX_FACTOR : (sx >> FRAC_BITS);
      ey = (sy >> FRAC_BITS) > MAX_FACTOR ? MAX_FACTOR : (sy >> FRAC_BITS);
      ox = x_org >> FRAC_BITS;
      oy = y_org >> FRAC_BITS;
      if (orow < out_h && row >= oy && row < oy + ey && ocol < out_w &&
          ocol < MAX_OUT_WIDTH && col >= ox && col < ox + ex) begin
         if (yuv) begin
            a = col[0] ? pix[23:16] : pix[7:0];
            b = pix[15:8];
            d = pix[31:24];
         end else begin
            a = pix[14:10];
            b = pix[9:5];
            d = pix[4:0];
         end
         if (row == oy && col == ox) begin
            lane_sum[ocol][0] = a; lane_sum[ocol][1] = b; lane_sum[ocol][2] = d;
         end else begin
            lane_sum[ocol][0] += a; lane_sum[ocol][1] += b; lane_sum[ocol][2] += d;
         end
         if (col == ox + ex - 1) begin
            if (row == oy + ey - 1) begin
               cnt = 32'(ex * ey);
               a = lane_sum[ocol][0]; b = lane_sum[ocol][1]; d = lane_sum[ocol][2];
               last_col = (ocol == out_w - 1);
               last = last_col && (orow == out_h - 1);
               if (yuv) begin
                  a /= cnt; b /= cnt; d /= cnt;
                  if (ocol[0]) begin
                     w.data = even_word | (32'(a & 255) << 16);
                     w.last = last;
                     expected_words.push_back(w);
                  end else begin
                     even_word = 32'(a & 255) | (32'(b & 255) << 8) | (32'(d & 255) << 24);
                     if (last_col) begin
                        w.data = even_word;
                        w.last = last;
                        expected_words.push_back(w);
                     end
                  end
               end else begin
                  if (cnt > 1) begin
                     a /= cnt; b /= cnt; d /= cnt;
                  end
                  w.data = 32'h8000 | (32'(a & 31) << 10) | (32'(b & 31) << 5) | 32'(d & 31);
                  w.last = last;
                  expected_words.push_back(w);
               end
            end
            ocol++;
            x_org += sx;
         end
      end
      if (col + 1 >= in_w) begin
         col = 0; x_org = 0; ocol = 0;
         if (orow < out_h && row + 1 >= oy + ey) begin
            orow++;
            y_org += sy;
         end
         if (row + 1 >= in_h) begin
            row = 0; y_org = 0; orow = 0;
         end else begin
            row++;
         end
      end else begin
         col++;
      end
   endfunction

   function void check_word(logic [31:0] data, logic last);
      out_word_type w;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected output word data=%h last=%b", data, last);
         return;
      end
      w = expected_words.pop_front();
      if (data !== w.data || last !== w.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("output mismatch: expected data=%h last=%b, got data=%h last=%b",
                     w.data, w.last, data, last);
      end
   endfunction
endclass

module box_filter_frame_downscaler_tb;
   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   bfd_req_if req ();
   bfd_rsp_if rsp ();

   downscale_scoreboard sb = new();

   // quiet: no idling on either side; long_hold: receiver stall request
   bit quiet = 0;
   bit long_hold = 0;
   int pixels_sent = 0;

   box_filter_frame_downscaler dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.pixel_data = '0;
      req.start_of_frame = 0;
      rsp.ready = 0;
   end

   // output monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_word(rsp.out_data, rsp.last_of_frame);
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp.ready <= 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end else begin
            rsp.ready <= 1;
            @(negedge clock);
         end
      end
   end

   // register write: setup then access phase, called at a falling edge
   task automatic write_reg(reg_idx_type idx, logic [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.set_reg(idx, v);
   endtask

   task automatic set_sizes(int unsigned iw, int unsigned ih, int unsigned ow,
                            int unsigned oh, bit y);
      write_reg(REG_IN_WIDTH, iw);
      write_reg(REG_IN_HEIGHT, ih);
      write_reg(REG_OUT_WIDTH, ow);
      write_reg(REG_OUT_HEIGHT, oh);
      write_reg(REG_YUV_MODE, y);
   endtask

   // one pixel transfer; valid stays high when no gap follows
   task automatic send_pixel(logic [31:0] pix, logic sof);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req.valid <= 1;
      req.pixel_data <= pix;
      req.start_of_frame <= sof;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_pixel(pix, sof);
      if (sb.sizes_ok()) pixels_sent++;
      @(negedge clock);
   endtask

   // drain: all words back, then room for a pixel that closes no box
   task automatic settle();
      req.valid <= 0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // full frames of random pixels, the last cut in half if truncate is set; wrap frames may come without start flag
   task automatic send_frames(int nframes, bit truncate);
      int unsigned n;
      n = sb.in_w * sb.in_h;
      for (int f = 0; f < nframes; f++) begin
         for (int unsigned p = 0; p < n; p++) begin
            if (truncate && f == nframes - 1 && p == n / 2) break;
            send_pixel($urandom, p == 0 && (f == 0 || $urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int unsigned iw, ih, ow, oh;
      int phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: 1x1 boxes with no divide, field extremes
      set_sizes(4, 1, 4, 1, 0);
      send_pixel(32'h0000_0000, 1);
      send_pixel(32'hFFFF_FFFF, 0);
      send_pixel(32'h0000_7FFF, 0);
      send_pixel(32'hFFFF_8000, 0);
      settle();
      // yuv with odd output width, extremes of the word
      set_sizes(6, 2, 3, 1, 1);
      send_pixel(32'hFFFF_FFFF, 1);
      send_pixel(32'h0000_0000, 0);
      for (int i = 0; i < 10; i++) send_pixel(i[0] ? 32'hFFFF_FFFF : 32'h0, 0);
      // frame wrap without start flag
      for (int i = 0; i < 6; i++) send_pixel($urandom, 0);
      settle();
      // invalid sizes: pixels ignored
      set_sizes(4, 2, 6, 1, 0);
      send_pixel($urandom, 1);
      send_pixel($urandom, 0);
      settle();

      // extreme settings: largest sizes (part of the first row only), largest boxes
      set_sizes(2048, 2048, 1024, 1024, 0);
      for (int i = 0; i < 150; i++) send_pixel($urandom, i == 0);
      settle();
      set_sizes(34, 17, 2, 1, 1);
      send_frames(1, 0);
      settle();
      set_sizes(2, 1, 2, 1, 0);
      send_frames(8, 0);
      settle();

      phase = 0;
      while (pixels_sent < 1500) begin
         phase++;
         if (phase == 3) long_hold = 1;
         if (pixels_sent > 1250) quiet = 1;
         if (phase == 3) begin
            // many results in a row while the receiver holds off
            set_sizes(16, 4, 16, 4, 0);
            send_frames(1, 0);
         end else if ($urandom_range(0, 9) == 0) begin
            // broken sizes: zero, oversized or output above input
            case ($urandom_range(0, 3))
               0: set_sizes(0, 4, 2, 1, $urandom_range(0, 1));
               1: set_sizes($urandom_range(2049, 4095), 2, 2, 1, 0);
               2: set_sizes(8, 4, $urandom_range(1025, 2047), 1, 1);
               default: set_sizes(4, 2, 2, 3, 0);
            endcase
            for (int i = 0; i < 5; i++) send_pixel($urandom, i == 0);
         end else begin
            iw = $urandom_range(2, 24);
            ih = $urandom_range(1, 8);
            ow = $urandom_range(2, iw);
            oh = $urandom_range(1, ih);
            set_sizes(iw, ih, ow, oh, $urandom_range(0, 1));
            send_frames($urandom_range(1, 3), $urandom_range(0, 4) == 0);
         end
         settle();
      end

      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_req_if.sv
hw/rtl/bfd_rsp_if.sv
hw/rtl/bfd_step.sv
hw/rtl/bfd_avg.sv
hw/rtl/box_filter_frame_downscaler.sv
hw/rtl/bfd_chk.sv
tb/sv/box_filter_frame_downscaler_tb.sv
